FILE: rtl/element_energy_update_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the element energy update block
// Concurrent assertion wrappers that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ELEMENT_ENERGY_UPDATE_MACROS_SVH
`define ELEMENT_ENERGY_UPDATE_MACROS_SVH
`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define EEU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("element_energy_update assertion failed");
// Antecedent implies consequent in the following cycle.
`define EEU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("element_energy_update assertion failed");
`else
`define EEU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define EEU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/eeu_pkg.sv
// ----------------------------------------------------------------------------
// Element energy update package
// Widths, register indexes, controller and item types and a shared saturation helper.
// ----------------------------------------------------------------------------
package eeu_pkg;

	localparam int DATA_W        = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int ALPHA_W       = 17;
	localparam int ALPHA_BITS    = 16;
	localparam int DIMS_W        = 2;
	localparam int CFG_IDX_W     = 2;
	localparam int SUM_W         = DATA_W + 1;
	localparam int WIDE_W        = 2 * DATA_W;
	localparam int ACC_W         = WIDE_W + 1;
	localparam int AK_W          = ALPHA_W + DATA_W;
	localparam int MAG_W         = WIDE_W;
	localparam int CHUNK_W       = 16;
	localparam int MUL_STEPS     = MAG_W / CHUNK_W;
	localparam int PP_W          = AK_W + CHUNK_W;
	localparam int PROD_W        = AK_W + MAG_W;
	localparam int DIV_W         = DATA_W + ALPHA_BITS;
	localparam int Q_W           = 34;
	localparam int NHI_W         = PROD_W - Q_W;
	localparam int REM2_W        = DIV_W + 1;
	localparam int RES_W         = Q_W + 1;
	localparam int CNT_W         = 6;

	localparam logic [CFG_IDX_W-1:0] REG_STAGE_WT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT = 2'd2;

	localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd65536;
	localparam logic [DIMS_W-1:0]  DIMS_RST  = 2'd3;
	localparam logic [DIMS_W-1:0]  DIMS_AXI  = 2'd2;

	localparam logic signed [WIDE_W-1:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [WIDE_W-1:0] S64_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
	localparam logic [Q_W-1:0] Q_CLAMP = {1'b1, {(Q_W-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TERM,
		ST_ACC,
		ST_AK,
		ST_MUL,
		ST_DIV_INIT,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic term;
		logic acc;
		logic ak;
		logic mstep;
		logic dinit;
		logic dstep;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic mass_zero;
		logic ovf;
		logic out_free;
	} status_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] corner_force;
		logic signed [DATA_W-1:0] vel_old;
		logic signed [DATA_W-1:0] vel_new;
		logic signed [DATA_W-1:0] node_y;
		logic signed [DATA_W-1:0] sie_old;
		logic [DATA_W-1:0]        elem_mass;
		logic                     last_of_element;
	} item_t;

	// Saturate a signed 64-bit value to the signed 32-bit range.
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic fits;
		fits = (&v[WIDE_W-1:DATA_W-1]) || !(|v[WIDE_W-1:DATA_W-1]);
		if (fits) begin
			return v[DATA_W-1:0];
		end else if (v[WIDE_W-1]) begin
			return S32_MIN;
		end else begin
			return S32_MAX;
		end
	endfunction

endpackage

FILE: rtl/eeu_if.sv
// ----------------------------------------------------------------------------
// Element energy update channel interfaces
// Valid/ready channels for input terms, results and register writes.
// ----------------------------------------------------------------------------
interface eeu_item_if;
	import eeu_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] corner_force;
	logic signed [DATA_W-1:0] vel_old;
	logic signed [DATA_W-1:0] vel_new;
	logic signed [DATA_W-1:0] node_y;
	logic signed [DATA_W-1:0] sie_old;
	logic [DATA_W-1:0]        elem_mass;
	logic                     last_of_element;

	modport source (
		output valid, corner_force, vel_old, vel_new, node_y, sie_old, elem_mass,
			last_of_element,
		input  ready
	);
	modport sink (
		input  valid, corner_force, vel_old, vel_new, node_y, sie_old, elem_mass,
			last_of_element,
		output ready
	);
endinterface

interface eeu_result_if;
	import eeu_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] sie_new;
	logic                     mass_zero;

	modport source (output valid, sie_new, mass_zero, input ready);
	modport sink (input valid, sie_new, mass_zero, output ready);
endinterface

interface eeu_cfg_if;
	import eeu_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/eeu_ctrl.sv
// ----------------------------------------------------------------------------
// Element energy update controller
// Sequences term accumulation and the per-element scale and divide.
// ----------------------------------------------------------------------------
`include "element_energy_update_macros.svh"

module eeu_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  eeu_pkg::status_t status,
	output eeu_pkg::cmd_t    cmd
);
	import eeu_pkg::*;

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_AK, ST_DIV_INIT: cnt_q <= '0;
				ST_MUL, ST_DIV:     cnt_q <= cnt_q + 1'b1;
				default:            cnt_q <= cnt_q;
			endcase
			// A term that is not the element's last is added while the next one loads.
			if (state_q == ST_TERM && !status.last) begin
				pend_q <= 1'b1;
			end else if (state_q == ST_IDLE) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_TERM;
			end
			ST_TERM: begin
				state_d = status.last ? ST_ACC : ST_IDLE;
			end
			ST_ACC: begin
				state_d = status.mass_zero ? ST_FIN : ST_AK;
			end
			ST_AK: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				if (cnt_q == CNT_W'(MUL_STEPS - 1)) state_d = ST_DIV_INIT;
			end
			ST_DIV_INIT: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (status.ovf || cnt_q == CNT_W'(Q_W - 1)) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				cmd.load   = item_valid;
				cmd.acc    = pend_q;
			end
			ST_TERM:     cmd.term   = 1'b1;
			ST_ACC:      cmd.acc    = 1'b1;
			ST_AK:       cmd.ak     = 1'b1;
			ST_MUL:      cmd.mstep  = 1'b1;
			ST_DIV_INIT: cmd.dinit  = 1'b1;
			ST_DIV:      cmd.dstep  = !status.ovf;
			ST_FIN:      cmd.finish = status.out_free;
			default: begin
				cmd        = '0;
				item_ready = 1'b0;
			end
		endcase
	end

	// The pending addition must drain before the next product overwrites it.
	`EEU_ASSERT_IMP(a_pend_drained, clk, arst_n, state_q == ST_TERM, !pend_q)
	// The divider never runs past its quotient width.
	`EEU_ASSERT_IMP(a_div_count, clk, arst_n, state_q == ST_DIV, cnt_q < CNT_W'(Q_W))

endmodule

FILE: rtl/eeu_dp.sv
// ----------------------------------------------------------------------------
// Element energy update datapath
// Configuration registers, term multiplier, accumulator, scale and divider.
// ----------------------------------------------------------------------------
`include "element_energy_update_macros.svh"

module eeu_dp #(
	parameter int FRAC_BITS = eeu_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  eeu_pkg::cmd_t                    cmd,
	output eeu_pkg::status_t                 status,
	input  eeu_pkg::item_t                   itm,
	input  logic                             cfg_we,
	input  logic [eeu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [eeu_pkg::DATA_W-1:0]       cfg_data,
	input  logic                             res_ready,
	output logic                             res_valid,
	output logic signed [eeu_pkg::DATA_W-1:0] res_sie_new,
	output logic                             res_mass_zero
);
	import eeu_pkg::*;

	// Configuration registers.
	logic [ALPHA_W-1:0] stage_wt_q;
	logic [DATA_W-1:0]  time_step_q;
	logic [DIMS_W-1:0]  dims_q;

	// Term path.
	logic signed [DATA_W-1:0] force_in;
	logic signed [DATA_W-1:0] node_y_in;
	logic signed [DATA_W-1:0] vel_old_in;
	logic signed [DATA_W-1:0] vel_new_in;
	logic signed [WIDE_W-1:0] rad_prod;
	logic signed [WIDE_W-1:0] rad_shift;
	logic signed [DATA_W-1:0] fr_next;
	logic signed [SUM_W-1:0]  vsum;
	logic signed [DATA_W-1:0] fr_s1;
	logic signed [DATA_W-1:0] half_s1;
	logic signed [WIDE_W-1:0] prod_s2;
	logic signed [WIDE_W-1:0] term;
	logic signed [ACC_W-1:0]  acc_sum;
	logic signed [WIDE_W-1:0] acc_next;
	logic signed [WIDE_W-1:0] psum_q;

	// Element registers.
	logic signed [DATA_W-1:0] sie_q;
	logic [DATA_W-1:0]        mass_q;
	logic                     last_q;

	// Scale and divide.
	logic [AK_W-1:0]   ak_q;
	logic [MAG_W-1:0]  mag_q;
	logic              neg_q;
	logic [PP_W-1:0]   pp;
	logic [PROD_W-1:0] n_q;
	logic [DIV_W-1:0]  div_d;
	logic              ovf_q;
	logic [DIV_W-1:0]  rem_q;
	logic [Q_W-1:0]    nlow_q;
	logic [Q_W-1:0]    q_q;
	logic [REM2_W-1:0] rem2;
	logic              ge;

	// Result.
	logic [Q_W-1:0]           qc;
	logic signed [RES_W-1:0]  sie_w;
	logic signed [RES_W-1:0]  qc_w;
	logic signed [RES_W-1:0]  res_w;
	logic signed [DATA_W-1:0] sie_next;
	logic                     mass_zero;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_sie_q;
	logic                     out_mz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_wt_q  <= ALPHA_RST;
			time_step_q <= '0;
			dims_q      <= DIMS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STAGE_WT:  stage_wt_q  <= cfg_data[ALPHA_W-1:0];
				REG_TIME_STEP: time_step_q <= cfg_data;
				REG_DIM_COUNT: dims_q      <= cfg_data[DIMS_W-1:0];
				default:       stage_wt_q  <= stage_wt_q;
			endcase
		end
	end

	assign force_in   = itm.corner_force;
	assign node_y_in  = itm.node_y;
	assign vel_old_in = itm.vel_old;
	assign vel_new_in = itm.vel_new;
	assign rad_prod   = WIDE_W'(force_in) * WIDE_W'(node_y_in);
	assign rad_shift  = rad_prod >>> FRAC_BITS;
	assign fr_next    = (dims_q == DIMS_AXI) ? sat32(rad_shift) : force_in;
	assign vsum       = SUM_W'(vel_old_in) + SUM_W'(vel_new_in);

	assign term     = prod_s2 >>> FRAC_BITS;
	assign acc_sum  = ACC_W'(psum_q) + ACC_W'(term);
	assign acc_next = (acc_sum[ACC_W-1] != acc_sum[ACC_W-2])
		? (acc_sum[ACC_W-1] ? S64_MIN : S64_MAX) : acc_sum[WIDE_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fr_s1   <= fr_next;
			half_s1 <= vsum[SUM_W-1:1];
			sie_q   <= itm.sie_old;
			mass_q  <= itm.elem_mass;
			last_q  <= itm.last_of_element;
		end
		if (cmd.term) begin
			prod_s2 <= WIDE_W'(fr_s1) * WIDE_W'(half_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psum_q <= '0;
		end else if (cmd.finish) begin
			psum_q <= '0;
		end else if (cmd.acc) begin
			psum_q <= acc_next;
		end
	end

	assign pp    = PP_W'(ak_q) * PP_W'(mag_q[MAG_W-1 -: CHUNK_W]);
	assign div_d = {mass_q, ALPHA_BITS'(0)};
	assign rem2  = {rem_q, nlow_q[Q_W-1]};
	assign ge    = rem2 >= REM2_W'(div_d);

	always_ff @(posedge clk) begin
		if (cmd.ak) begin
			ak_q  <= AK_W'(stage_wt_q) * AK_W'(time_step_q);
			mag_q <= psum_q[WIDE_W-1] ? MAG_W'(0) - MAG_W'(psum_q) : MAG_W'(psum_q);
			neg_q <= psum_q[WIDE_W-1];
			n_q   <= '0;
		end
		if (cmd.mstep) begin
			// Most significant chunk first, so the partial sum shifts up each step.
			n_q   <= (n_q << CHUNK_W) + PROD_W'(pp);
			mag_q <= mag_q << CHUNK_W;
		end
		if (cmd.dinit) begin
			ovf_q  <= n_q[PROD_W-1:Q_W] >= NHI_W'(div_d);
			rem_q  <= n_q[Q_W+DIV_W-1:Q_W];
			nlow_q <= n_q[Q_W-1:0];
			q_q    <= '0;
		end
		if (cmd.dstep) begin
			rem_q  <= ge ? DIV_W'(rem2 - REM2_W'(div_d)) : rem2[DIV_W-1:0];
			nlow_q <= nlow_q << 1;
			q_q    <= {q_q[Q_W-2:0], ge};
		end
	end

	assign mass_zero = (mass_q == '0);
	assign qc        = (ovf_q || q_q > Q_CLAMP) ? Q_CLAMP : q_q;
	assign sie_w     = RES_W'(sie_q);
	assign qc_w      = $signed(RES_W'(qc));
	assign res_w     = neg_q ? sie_w + qc_w : sie_w - qc_w;
	assign sie_next  = mass_zero ? sie_q : sat32(WIDE_W'(res_w));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_sie_q <= sie_next;
			out_mz_q  <= mass_zero;
		end
	end

	assign res_valid     = out_valid_q;
	assign res_sie_new   = out_sie_q;
	assign res_mass_zero = out_mz_q;

	assign status.last      = last_q;
	assign status.mass_zero = mass_zero;
	assign status.ovf       = ovf_q;
	assign status.out_free  = !out_valid_q || res_ready;

	// Restoring division keeps the partial remainder below the divisor.
	`EEU_ASSERT_IMP(a_rem_bound, clk, arst_n, cmd.dstep, rem_q < div_d)
	// The accumulator starts every element from zero.
	`EEU_ASSERT_NXT(a_sum_cleared, clk, arst_n, cmd.finish, psum_q == '0)

endmodule

FILE: rtl/element_energy_update.sv
// ----------------------------------------------------------------------------
// Element energy update
// Accumulates corner power per element and applies the energy update.
// ----------------------------------------------------------------------------
// Each request is one corner-dimension term of an element. For a term that is
// not the element's last, the force (radius-weighted when two dimensions are
// configured) and the mean velocity are registered when it is accepted, then
// the 32 by 32 term product is registered; its addition into the saturating
// 64-bit power sum overlaps the acceptance of the next request. The element's
// last term holds off the next request until its steps are done: the term
// product and its addition, the stage weight times the time step, a 49 by 16
// multiplier that forms the 113-bit scaled power from 16-bit chunks of its
// magnitude, a divider setup step and a restoring divider that produces one
// quotient bit per cycle of a 34-bit quotient against elem_mass shifted up 16
// bits, then a step that writes the output register. A quotient known to
// exceed the clamp skips the division, and a zero mass skips the scale and
// divide entirely. The result waits in an output register, so new terms are
// taken while it is unclaimed; only a second finished element waits for it.
// Register writes are taken on any cycle and belong between elements.

module element_energy_update #(
	parameter int FRAC_BITS = eeu_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	eeu_item_if.sink    item,
	eeu_result_if.source result,
	eeu_cfg_if.sink     cfg
);
	import eeu_pkg::*;

	cmd_t    cmd;
	status_t status;
	item_t   itm;
	logic    item_ready;

	// Pack the request fields for the datapath.
	assign itm.corner_force    = item.corner_force;
	assign itm.vel_old         = item.vel_old;
	assign itm.vel_new         = item.vel_new;
	assign itm.node_y          = item.node_y;
	assign itm.sie_old         = item.sie_old;
	assign itm.elem_mass       = item.elem_mass;
	assign itm.last_of_element = item.last_of_element;

	assign item.ready = item_ready;

	// Register writes are always accepted.
	assign cfg.ready = 1'b1;

	eeu_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	eeu_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.itm           (itm),
		.cfg_we        (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.res_ready     (result.ready),
		.res_valid     (result.valid),
		.res_sie_new   (result.sie_new),
		.res_mass_zero (result.mass_zero)
	);

endmodule
